[hdl/yte_pkg.sv]
// Shared types, sizes and helpers for the Young tableau extract-min unit.
// No dependencies; yte_store, yte_ctrl and the top level import this package.
package yte_pkg;

  localparam int ROWS       = 8;
  localparam int COLS       = 8;
  localparam int VALUE_BITS = 16;

  localparam int ROW_BITS   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_BITS   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CELL_COUNT = ROWS * COLS;
  localparam int ADDR_BITS  = $clog2(CELL_COUNT);

  localparam logic [VALUE_BITS-1:0] MARKER_RESET = VALUE_BITS'(100);

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_SIFT    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SIFT
  } state_t;

  // Request from the controller to the cell store.
  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  clear;
    logic [VALUE_BITS-1:0] clear_value;
    logic [ADDR_BITS-1:0]  raddr_a;
    logic [ADDR_BITS-1:0]  raddr_b;
  } store_req_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [ROW_BITS-1:0] r,
                                                     input logic [COL_BITS-1:0] c);
    cell_addr = ADDR_BITS'(32'(r) * COLS + 32'(c));
  endfunction

endpackage

[hdl/yte_req_if.sv]
// Request channel of the tableau unit: valid/ready plus mode, cell and value.
// Stand-alone; field widths are fixed by the channel definition.
interface yte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  row;
  logic [2:0]  col;
  logic [15:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

[hdl/yte_res_if.sv]
// Result channel of the tableau unit: valid/ready plus extracted value and flag.
// Stand-alone; field widths are fixed by the channel definition.
interface yte_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] min_value;
  logic        was_empty;

  modport source (output valid, min_value, was_empty, input ready);
  modport sink   (input valid, min_value, was_empty, output ready);
endinterface

[hdl/yte_store.sv]
// Cell store: one synchronous memory with two registered read ports and one
// write port, plus per-cell filled bits so a clear needs no pass over the cells. Uses yte_pkg.
module yte_store (
  input  logic                           clk,
  input  logic                           rst,
  input  yte_pkg::store_req_t            req,
  output logic [yte_pkg::VALUE_BITS-1:0] rdata_a,
  output logic [yte_pkg::VALUE_BITS-1:0] rdata_b
);
  import yte_pkg::*;

  logic [VALUE_BITS-1:0] mem [CELL_COUNT];
  logic [VALUE_BITS-1:0] mem_a;
  logic [VALUE_BITS-1:0] mem_b;
  logic [CELL_COUNT-1:0] filled;
  logic                  filled_a;
  logic                  filled_b;
  logic [VALUE_BITS-1:0] fill_value;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    mem_a <= mem[req.raddr_a];
    mem_b <= mem[req.raddr_b];
  end

  always_ff @(posedge clk) begin
    filled_a <= filled[req.raddr_a];
    filled_b <= filled[req.raddr_b];
  end

  // A cell that has not been written since the last clear reads as the
  // marker that was current at that clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled     <= '0;
      fill_value <= MARKER_RESET;
    end else if (req.clear) begin
      filled     <= '0;
      fill_value <= req.clear_value;
    end else if (req.we) begin
      filled[req.waddr] <= 1'b1;
    end
  end

  assign rdata_a = filled_a ? mem_a : fill_value;
  assign rdata_b = filled_b ? mem_b : fill_value;

endmodule

[hdl/yte_ctrl.sv]
// Sequencer of the tableau unit: decodes requests, walks the sift-down one
// cell per cycle against the cell store and holds the result register. Uses yte_pkg.
module yte_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [15:0]                    cfg_wr_data,
  yte_req_if.sink                        request,
  yte_res_if.source                      result,
  output yte_pkg::store_req_t            store_req,
  input  logic [yte_pkg::VALUE_BITS-1:0] rdata_a,
  input  logic [yte_pkg::VALUE_BITS-1:0] rdata_b
);
  import yte_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [ROW_BITS-1:0]   pos_r;
  logic [COL_BITS-1:0]   pos_c;
  logic [VALUE_BITS-1:0] cur;
  logic                  extract;
  logic [VALUE_BITS-1:0] marker;
  logic                  res_valid;
  logic [15:0]           res_min;
  logic                  res_empty;

  logic                  accept;
  logic                  in_table;
  logic                  slot_free;
  logic [ADDR_BITS-1:0]  here;
  logic [ADDR_BITS-1:0]  next_here;
  logic                  has_right;
  logic                  has_down;
  logic                  go_right;
  logic [VALUE_BITS-1:0] pick_value;
  logic                  stop;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign in_table      = (32'(request.row) < ROWS) && (32'(request.col) < COLS);
  assign slot_free     = !res_valid || result.ready;

  assign result.valid     = res_valid;
  assign result.min_value = res_min;
  assign result.was_empty = res_empty;

  // Port A carries the right neighbor and port B the lower one during a walk.
  assign here      = cell_addr(pos_r, pos_c);
  assign has_right = (pos_c != COL_BITS'(COLS - 1));
  assign has_down  = (pos_r != ROW_BITS'(ROWS - 1));

  always_comb begin
    if (has_right && has_down) begin
      go_right = (rdata_a <= rdata_b);
    end else begin
      go_right = has_right;
    end
    pick_value = go_right ? rdata_a : rdata_b;
    next_here  = go_right ? here + ADDR_BITS'(1) : here + ADDR_BITS'(COLS);
    // The walk ends at the corner, when every existing neighbor is empty,
    // or when the chosen neighbor is not smaller than the moving value.
    stop = (!has_right && !has_down)
        || ((!has_right || rdata_a == marker) && (!has_down || rdata_b == marker))
        || !(pick_value < cur);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (request.mode == MODE_EXTRACT ||
                       (request.mode == MODE_SIFT && in_table))) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // An extract waits here until the result register can take its value.
        if (!extract || slot_free) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_SIFT;
      end
      ST_SIFT: begin
        if (stop) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    store_req         = '0;
    store_req.raddr_a = here + ADDR_BITS'(1);
    store_req.raddr_b = here + ADDR_BITS'(COLS);
    unique case (state)
      ST_IDLE: begin
        if (accept && request.mode == MODE_WRITE && in_table) begin
          store_req.we    = 1'b1;
          store_req.waddr = cell_addr(ROW_BITS'(request.row), COL_BITS'(request.col));
          store_req.wdata = VALUE_BITS'(request.value);
        end
        if (accept && request.mode == MODE_CLEAR) begin
          store_req.clear       = 1'b1;
          store_req.clear_value = marker;
        end
      end
      ST_FETCH: begin
        store_req.raddr_a = here;
      end
      ST_LOAD: begin
      end
      ST_SIFT: begin
        // Only the neighbor moves up each step; the walking value is written
        // once, where the walk ends.
        store_req.we      = 1'b1;
        store_req.waddr   = here;
        store_req.wdata   = stop ? cur : pick_value;
        store_req.raddr_a = next_here + ADDR_BITS'(1);
        store_req.raddr_b = next_here + ADDR_BITS'(COLS);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      marker    <= MARKER_RESET;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        marker <= VALUE_BITS'(cfg_wr_data);
      end
      if (state == ST_LOAD && extract) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          extract <= (request.mode == MODE_EXTRACT);
          if (request.mode == MODE_EXTRACT) begin
            pos_r <= '0;
            pos_c <= '0;
          end else begin
            pos_r <= ROW_BITS'(request.row);
            pos_c <= COL_BITS'(request.col);
          end
        end
      end
      ST_FETCH: begin
      end
      ST_LOAD: begin
        cur <= extract ? marker : rdata_a;
        if (extract) begin
          res_min   <= 16'(rdata_a);
          res_empty <= (rdata_a == marker);
        end
      end
      ST_SIFT: begin
        if (!stop) begin
          if (go_right) begin
            pos_c <= pos_c + COL_BITS'(1);
          end else begin
            pos_r <= pos_r + ROW_BITS'(1);
          end
        end
      end
    endcase
  end

endmodule

[hdl/young_tableau_extract_min_unit.sv]
// Young tableau extract-min unit: top level, joins the sequencer and the cell store.
// Depends on yte_pkg, yte_req_if, yte_res_if, yte_store and yte_ctrl.
//
// The unit keeps a ROWS x COLS Young tableau in one memory with two read ports
// and one write port. A write-cell or clear request goes to the store as it is
// accepted, and the unit stays ready; the clear works through per-cell filled
// bits, so there is no clearing pass after reset or after a clear. An extract
// or a sift-down runs in steps: it is accepted, the start cell is read, it is
// loaded and its neighbors are read, then the walk takes one cell per cycle and
// visits at most ROWS + COLS - 1 cells. Each step reads both neighbors through
// the two read ports while the neighbor that moves up is written back. An
// extract also waits before loading while the previous result has not been
// transferred. New requests are taken while a finished result waits.
module young_tableau_extract_min_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  yte_req_if.sink     request,
  yte_res_if.source   result
);
  import yte_pkg::*;

  store_req_t            store_req;
  logic [VALUE_BITS-1:0] rdata_a;
  logic [VALUE_BITS-1:0] rdata_b;

  yte_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .request     (request),
    .result      (result),
    .store_req   (store_req),
    .rdata_a     (rdata_a),
    .rdata_b     (rdata_b)
  );

  yte_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // While the unit is ready, the only store write is an accepted cell write.
  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    (store_req.we && request.ready) |-> (request.valid && request.mode == MODE_WRITE))
    else $error("store write while idle without a write request");

  // A clear comes only from an accepted clear request.
  a_clear_src: assert property (@(posedge clk) disable iff (rst)
    store_req.clear |-> (request.valid && request.ready && request.mode == MODE_CLEAR))
    else $error("store clear without a clear request");

  // A new result appears only while its extract is still walking.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> !request.ready)
    else $error("result raised while the unit was idle");

  // Clear and write never reach the store together.
  a_no_clear_write: assert property (@(posedge clk) disable iff (rst)
    !(store_req.clear && store_req.we))
    else $error("store clear and write in the same cycle");

endmodule
